// ===== rtl/core/imufd_pkg.sv =====
// Shared types, constants and CRC functions for the IMU frame deframer.
package imufd_pkg;

    // Framing bytes.
    localparam logic [7:0] HEAD_BYTE = 8'hFC;
    localparam logic [7:0] END_BYTE  = 8'hFD;

    // CRC polynomials: reflected CRC-8 and MSB-first CRC-16.
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_POLY = 16'h1021;

    // Known frame types and the fixed payload lengths of some of them.
    localparam logic [7:0] TYPE_IMU    = 8'h40;
    localparam logic [7:0] TYPE_AHRS   = 8'h41;
    localparam logic [7:0] TYPE_INSGPS = 8'h42;
    localparam logic [7:0] TYPE_GROUND = 8'h5C;
    localparam logic [7:0] TYPE_RAW    = 8'hF0;
    localparam logic [7:0] TYPE_SYS    = 8'h50;
    localparam logic [7:0] LEN_IMU     = 8'h38;
    localparam logic [7:0] LEN_AHRS    = 8'h30;
    localparam logic [7:0] LEN_INSGPS  = 8'h48;
    localparam logic [7:0] LEN_GROUND  = 8'h20;

    // Number of header bytes after the head byte, less one.
    localparam logic [2:0] HDR_LAST = 3'd5;

    // Reset value of the gap limit register.
    localparam logic [15:0] GAP_LIMIT_RESET = 16'd20;

    // Input item kinds and result kinds.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TICK    = 1'b1;
    localparam logic OUT_PAYLOAD  = 1'b0;
    localparam logic OUT_VERDICT  = 1'b1;

    // Frame verdict codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TYPE    = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_HCRC    = 3'd3,
        ST_PCRC    = 3'd4,
        ST_END     = 3'd5,
        ST_TIMEOUT = 3'd6
    } status_t;

    // One input item.
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    // One result item, with a flag that says whether the step produces it.
    typedef struct packed {
        logic       valid;
        logic       out_kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [7:0] frame_serial;
        status_t    status;
    } result_t;

    // Reflected CRC-8 over one byte, unrolled over its eight bits.
    function automatic logic [7:0] crc8_feed(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC8_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // MSB-first CRC-16 over one byte, unrolled over its eight bits.
    function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC16_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

    // True when the frame type is one that the link defines.
    function automatic logic type_known(input logic [7:0] t);
        return (t == TYPE_IMU) || (t == TYPE_AHRS) || (t == TYPE_INSGPS) ||
               (t == TYPE_GROUND) || (t == TYPE_RAW) || (t == TYPE_SYS);
    endfunction

    // True when the length suits the type; types without a fixed length take any.
    function automatic logic length_fits(input logic [7:0] t, input logic [7:0] n);
        logic ok;
        ok = 1'b1;
        if (t == TYPE_IMU)
        begin
            ok = (n == LEN_IMU);
        end
        else if (t == TYPE_AHRS)
        begin
            ok = (n == LEN_AHRS);
        end
        else if (t == TYPE_INSGPS)
        begin
            ok = (n == LEN_INSGPS);
        end
        else if (t == TYPE_GROUND)
        begin
            ok = (n == LEN_GROUND);
        end
        return ok;
    endfunction

endpackage

// ===== rtl/core/imu_frame_deframer_crc_core.sv =====
// Top level of the IMU serial frame deframer with header CRC-8 and payload CRC-16.
//
//   Channel   Direction  Handshake             Payload
//   in        sink       in_valid / in_stall   kind, rx_byte
//   out       source     out_valid / out_stall out_kind, payload_byte, byte_index,
//                                              frame_type, frame_length, frame_serial, status
//   cfg       sink       cfg_valid / cfg_ready cfg_data (gap limit in ticks)
//
// One item is accepted per cycle while in_stall is low; its result is presented from the result register
// (the input register loads on the accepting edge, the result register when the item advances).
// The single-byte CRC-8/CRC-16 update lies between the two registers.
// Reset is asynchronous and active low; it clears the frame state and sets the gap limit to 20.
// A result held by out_stall stalls the input only when the waiting item would produce a result.
// The configuration port is always ready.
module imu_frame_deframer_crc_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  byte_index,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_length,
    output logic [7:0]  frame_serial,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic               cfg_write;
    logic [15:0]        gap_limit_reg;
    imufd_pkg::item_t   in_item;
    imufd_pkg::item_t   item;
    imufd_pkg::result_t res;
    imufd_pkg::result_t res_out;
    logic               in_full;
    logic               out_free;
    logic               advance;

    // Gap limit register, written by a configuration transaction.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= imufd_pkg::GAP_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            gap_limit_reg <= cfg_data;
        end
    end

    // An item moves on when it yields no result or the result register has room.
    assign advance = in_full && (!res.valid || out_free);

    assign in_item.kind    = kind;
    assign in_item.rx_byte = rx_byte;

    imufd_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .advance  (advance),
        .full     (in_full),
        .item     (item)
    );

    imufd_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (item),
        .gap_limit (gap_limit_reg),
        .res       (res)
    );

    imufd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res.valid),
        .res_in    (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .free      (out_free),
        .res_out   (res_out)
    );

    // Result fields onto their ports.
    assign out_kind     = res_out.out_kind;
    assign payload_byte = res_out.payload_byte;
    assign byte_index   = res_out.byte_index;
    assign frame_type   = res_out.frame_type;
    assign frame_length = res_out.frame_length;
    assign frame_serial = res_out.frame_serial;
    assign status       = 3'(res_out.status);

endmodule

// ===== rtl/core/imufd_in_reg.sv =====
// Input register: holds one accepted item until the engine takes it.
module imufd_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  imufd_pkg::item_t  in_item,
    input  logic              advance,
    output logic              full,
    output imufd_pkg::item_t  item
);

    logic             full_reg;
    logic             full_next;
    imufd_pkg::item_t item_reg;
    logic             load;

    // The register refuses a new transaction only while its item cannot move on.
    assign in_stall = full_reg && !advance;
    assign load     = in_valid && !in_stall;

    // Occupancy follows loads and departures.
    always_comb
    begin
        full_next = full_reg;
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule

// ===== rtl/core/imufd_engine.sv =====
// Deframing engine: frame state, CRC accumulation, checks and result forming.
module imufd_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  imufd_pkg::item_t    item,
    input  logic [15:0]         gap_limit,
    output imufd_pkg::result_t  res
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t       phase_reg,         phase_next;
    logic [2:0]   header_count_reg,  header_count_next;
    logic [7:0]   hdr_type_reg,      hdr_type_next;
    logic [7:0]   hdr_length_reg,    hdr_length_next;
    logic [7:0]   hdr_serial_reg,    hdr_serial_next;
    logic [7:0]   hdr_check8_reg,    hdr_check8_next;
    logic [15:0]  hdr_check16_reg,   hdr_check16_next;
    logic [7:0]   run_crc8_reg,      run_crc8_next;
    logic [15:0]  run_crc16_reg,     run_crc16_next;
    logic [7:0]   payload_count_reg, payload_count_next;
    logic [15:0]  gap_count_reg,     gap_count_next;

    logic                in_frame;
    logic [15:0]         limit;
    logic [7:0]          b;
    logic                verdict_hit;
    imufd_pkg::status_t  verdict_code;

    assign in_frame = (phase_reg == PH_HEADER) || (phase_reg == PH_PAYLOAD);
    assign limit    = (gap_limit == 16'd0) ? 16'd1 : gap_limit;
    assign b        = item.rx_byte;

    // Next state and result for the item in the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        hdr_type_next      = hdr_type_reg;
        hdr_length_next    = hdr_length_reg;
        hdr_serial_next    = hdr_serial_reg;
        hdr_check8_next    = hdr_check8_reg;
        hdr_check16_next   = hdr_check16_reg;
        run_crc8_next      = run_crc8_reg;
        run_crc16_next     = run_crc16_reg;
        payload_count_next = payload_count_reg;
        gap_count_next     = gap_count_reg;
        verdict_hit        = 1'b0;
        verdict_code       = imufd_pkg::ST_OK;
        res                = '0;

        if (item.kind == imufd_pkg::KIND_TICK)
        begin
            // Ticks count towards the gap limit only inside a frame.
            if (in_frame)
            begin
                gap_count_next = gap_count_reg + 16'd1;
                if (gap_count_next >= limit)
                begin
                    verdict_hit  = 1'b1;
                    verdict_code = imufd_pkg::ST_TIMEOUT;
                end
            end
        end
        else
        begin
            gap_count_next = '0;
            case (phase_reg)
                PH_HEADER:
                begin
                    case (header_count_reg)
                        3'd0:
                        begin
                            hdr_type_next = b;
                            run_crc8_next = imufd_pkg::crc8_feed(run_crc8_reg, b);
                        end
                        3'd1:
                        begin
                            hdr_length_next = b;
                            run_crc8_next   = imufd_pkg::crc8_feed(run_crc8_reg, b);
                        end
                        3'd2:
                        begin
                            hdr_serial_next = b;
                            run_crc8_next   = imufd_pkg::crc8_feed(run_crc8_reg, b);
                        end
                        3'd3:    hdr_check8_next  = b;
                        3'd4:    hdr_check16_next = {b, 8'h00};
                        default: hdr_check16_next = hdr_check16_reg | {8'h00, b};
                    endcase

                    // The last header byte triggers the three header checks in turn.
                    if (header_count_reg < imufd_pkg::HDR_LAST)
                    begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                    else if (!imufd_pkg::type_known(hdr_type_reg))
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_TYPE;
                    end
                    else if (!imufd_pkg::length_fits(hdr_type_reg, hdr_length_reg))
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_LENGTH;
                    end
                    else if (run_crc8_reg != hdr_check8_reg)
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_HCRC;
                    end
                    else
                    begin
                        phase_next         = PH_PAYLOAD;
                        payload_count_next = '0;
                        run_crc16_next     = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (payload_count_reg < hdr_length_reg)
                    begin
                        // Payload byte: pass it on with its index.
                        res.valid          = 1'b1;
                        res.out_kind       = imufd_pkg::OUT_PAYLOAD;
                        res.payload_byte   = b;
                        res.byte_index     = payload_count_reg;
                        run_crc16_next     = imufd_pkg::crc16_feed(run_crc16_reg, b);
                        payload_count_next = payload_count_reg + 8'd1;
                    end
                    else if (run_crc16_reg != hdr_check16_reg)
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_PCRC;
                    end
                    else if (b != imufd_pkg::END_BYTE)
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_END;
                    end
                    else
                    begin
                        verdict_hit  = 1'b1;
                        verdict_code = imufd_pkg::ST_OK;
                    end
                end
                default:
                begin
                    // Hunting, and any unused phase code: wait for the head byte.
                    if (b == imufd_pkg::HEAD_BYTE)
                    begin
                        phase_next         = PH_HEADER;
                        header_count_next  = '0;
                        hdr_type_next      = '0;
                        hdr_length_next    = '0;
                        hdr_serial_next    = '0;
                        hdr_check8_next    = '0;
                        hdr_check16_next   = '0;
                        run_crc8_next      = imufd_pkg::crc8_feed(8'h00, b);
                        run_crc16_next     = '0;
                        payload_count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end

        // A verdict ends the frame and returns to hunting.
        if (verdict_hit)
        begin
            res.valid          = 1'b1;
            res.out_kind       = imufd_pkg::OUT_VERDICT;
            res.payload_byte   = '0;
            res.byte_index     = '0;
            res.status         = verdict_code;
            phase_next         = PH_HUNT;
            header_count_next  = '0;
            payload_count_next = '0;
            gap_count_next     = '0;
        end

        res.frame_type   = hdr_type_next;
        res.frame_length = hdr_length_next;
        res.frame_serial = hdr_serial_next;
    end

    // Frame state advances only when the item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            header_count_reg  <= '0;
            hdr_type_reg      <= '0;
            hdr_length_reg    <= '0;
            hdr_serial_reg    <= '0;
            hdr_check8_reg    <= '0;
            hdr_check16_reg   <= '0;
            run_crc8_reg      <= '0;
            run_crc16_reg     <= '0;
            payload_count_reg <= '0;
            gap_count_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            hdr_type_reg      <= hdr_type_next;
            hdr_length_reg    <= hdr_length_next;
            hdr_serial_reg    <= hdr_serial_next;
            hdr_check8_reg    <= hdr_check8_next;
            hdr_check16_reg   <= hdr_check16_next;
            run_crc8_reg      <= run_crc8_next;
            run_crc16_reg     <= run_crc16_next;
            payload_count_reg <= payload_count_next;
            gap_count_reg     <= gap_count_next;
        end
    end

    // The payload counter never runs past the header length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_count_reg <= hdr_length_reg))
        else $error("payload count beyond frame length");

    // No gap is counted while hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (gap_count_reg == 16'd0))
        else $error("gap count running outside a frame");

    // A taken verdict always sends the engine back to hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.valid && (res.out_kind == imufd_pkg::OUT_VERDICT))
        |=> (phase_reg == PH_HUNT))
        else $error("verdict did not end the frame");

    // The header counter stays within the header.
    assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= imufd_pkg::HDR_LAST)
        else $error("header count out of range");

endmodule

// ===== rtl/core/imufd_out_reg.sv =====
// Result register: holds one result until the downstream side takes it.
module imufd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  imufd_pkg::result_t  res_in,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                free,
    output imufd_pkg::result_t  res_out
);

    logic               valid_reg;
    logic               valid_next;
    imufd_pkg::result_t res_reg;

    // Space exists when empty or when the held result leaves this cycle.
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
